### hdl/e2e22_pkg.sv
// Shared types, constants and CRC helpers for the profile 22 receive checker.
`default_nettype none
package e2e22_pkg;

   localparam int MAX_BYTES_DEFAULT = 256;

   localparam logic [7:0] CRC_POLY   = 8'h2F;
   localparam logic [7:0] CRC_INIT   = 8'hFF;
   localparam logic [7:0] CRC_XOROUT = 8'hFF;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_BYTES      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DATA_LENGTH_BYTES = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_DELTA_COUNTER = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DATA_ID_LOW       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DATA_ID_HIGH      = 3'd4;

   localparam logic [7:0] OFFSET_RESET      = 8'd0;
   localparam logic [8:0] DATA_LENGTH_RESET = 9'd8;
   localparam logic [3:0] MAX_DELTA_RESET   = 4'd1;
   localparam logic [3:0] LAST_COUNTER_RESET = 4'hF;

   localparam logic       RC_OK          = 1'b0;
   localparam logic       RC_INPUT_WRONG = 1'b1;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_OK_SOMELOST = 3'd1;
   localparam logic [2:0] ST_ERROR       = 3'd2;
   localparam logic [2:0] ST_REPEATED    = 3'd3;
   localparam logic [2:0] ST_NO_NEW_DATA = 3'd4;
   localparam logic [2:0] ST_WRONG_SEQ   = 3'd5;

   localparam logic [2:0] SM_OK          = 3'd0;
   localparam logic [2:0] SM_ERROR       = 3'd1;
   localparam logic [2:0] SM_REPEATED    = 3'd2;
   localparam logic [2:0] SM_NO_NEW_DATA = 3'd3;
   localparam logic [2:0] SM_WRONG_SEQ   = 3'd4;

   typedef struct packed {
      logic [7:0]  offset_bytes;
      logic [8:0]  data_length_bytes;
      logic [3:0]  max_delta_counter;
      logic [63:0] data_id_low;
      logic [63:0] data_id_high;
   } cfg_type;

   typedef struct packed {
      logic       return_code;
      logic [2:0] check_status;
      logic [2:0] mapped_status;
      logic [3:0] received_counter;
   } rsp_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [2:0] map_status(input logic [2:0] s);
      logic [2:0] m;
      case (s)
         ST_OK, ST_OK_SOMELOST: m = SM_OK;
         ST_REPEATED:           m = SM_REPEATED;
         ST_NO_NEW_DATA:        m = SM_NO_NEW_DATA;
         ST_WRONG_SEQ:          m = SM_WRONG_SEQ;
         default:               m = SM_ERROR;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

### hdl/e2e22_profile22_check_core.sv
// Top level of the profile 22 receive checker.
// Takes one message byte per word, one word per clock while req_stall is low, with
// no gaps between messages. Each word is registered, then CRC-8 (0x2F) and the
// counter checks run against the message state; a word with last_byte or no_data
// passes from the input register into the output register, which drives the
// response port. Such a word waits in the input register while a stalled result
// holds the output register. Configure only while idle.
`default_nettype none
module e2e_profile22_check_core
   import e2e22_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_last_byte,
   input  wire logic                   req_no_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_return_code,
   output logic [2:0]                  rsp_check_status,
   output logic [2:0]                  rsp_mapped_status,
   output logic [3:0]                  rsp_received_counter
);

   cfg_type cfg;
   rsp_type out_rsp;
   rsp_type rsp;
   logic    out_free;
   logic    out_load;

   e2e22_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   e2e22_eval #(
      .MAX_BYTES (MAX_BYTES)
   ) u_eval (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .req_no_data   (req_no_data),
      .out_free      (out_free),
      .out_load      (out_load),
      .out_rsp       (out_rsp)
   );

   e2e22_out u_out (
      .clock     (clock),
      .reset     (reset),
      .out_load  (out_load),
      .out_rsp   (out_rsp),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_return_code      = rsp.return_code;
   assign rsp_check_status     = rsp.check_status;
   assign rsp_mapped_status    = rsp.mapped_status;
   assign rsp_received_counter = rsp.received_counter;

endmodule
`default_nettype wire

### hdl/e2e22_csr.sv
// Configuration registers of the profile 22 receive checker.
`default_nettype none
module e2e22_csr
   import e2e22_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_OFFSET_BYTES:      cfg_in.offset_bytes      = csr_data[7:0];
            REG_DATA_LENGTH_BYTES: cfg_in.data_length_bytes = csr_data[8:0];
            REG_MAX_DELTA_COUNTER: cfg_in.max_delta_counter = csr_data[3:0];
            REG_DATA_ID_LOW:       cfg_in.data_id_low       = csr_data;
            REG_DATA_ID_HIGH:      cfg_in.data_id_high      = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_bytes      <= OFFSET_RESET;
         cfg_ff.data_length_bytes <= DATA_LENGTH_RESET;
         cfg_ff.max_delta_counter <= MAX_DELTA_RESET;
         cfg_ff.data_id_low       <= '0;
         cfg_ff.data_id_high      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### hdl/e2e22_eval.sv
// Input word register, message state and per-word CRC / counter evaluation.
`default_nettype none
module e2e22_eval
   import e2e22_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   input  wire logic       req_no_data,
   input  wire logic       out_free,
   output logic            out_load,
   output rsp_type         out_rsp
);

   localparam int CNT_W = $clog2(MAX_BYTES + 2);
   localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BYTES);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       s1_none_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       acc_ff, acc_in;
   logic [7:0]       cap_crc_ff, cap_crc_in;
   logic [3:0]       cap_cnt_ff, cap_cnt_in;
   logic [3:0]       last_counter_ff, last_counter_in;
   logic [2:0]       last_status_ff, last_status_in;

   logic             s1_adv;
   logic             req_take;
   logic             is_crc_pos;
   logic             is_cnt_pos;
   logic [7:0]       acc_upd;
   logic [7:0]       cap_crc_upd;
   logic [3:0]       cap_cnt_upd;
   logic [CNT_W-1:0] count_upd;
   logic             len_bad;
   logic [63:0]      ids;
   logic [7:0]       data_id;
   logic [7:0]       crc_rx;
   logic             crc_bad;
   logic [3:0]       delta;
   logic [2:0]       status;

   assign s1_adv    = !(s1_none_ff || s1_last_ff) || out_free;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;
   assign out_load  = s1_valid_ff && (s1_none_ff || s1_last_ff) && out_free;

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_adv);

   always_comb begin
      is_crc_pos  = CMP_W'(count_ff) == CMP_W'(cfg.offset_bytes);
      is_cnt_pos  = CMP_W'(count_ff) == CMP_W'({1'b0, cfg.offset_bytes} + 9'd1);
      acc_upd     = is_crc_pos ? acc_ff : crc8_update(acc_ff, s1_byte_ff);
      cap_crc_upd = is_crc_pos ? s1_byte_ff : cap_crc_ff;
      cap_cnt_upd = (!is_crc_pos && is_cnt_pos) ? (s1_byte_ff[3:0] & NIBBLE_MASK)
                                                : cap_cnt_ff;
      count_upd   = (count_ff <= MAX_CNT) ? count_ff + 1'b1 : count_ff;
      len_bad     = (CMP_W'(count_upd) != CMP_W'(cfg.data_length_bytes))
                 || (count_upd > MAX_CNT)
                 || (CMP_W'(count_upd) < CMP_W'({1'b0, cfg.offset_bytes} + 9'd2));
      ids         = cap_cnt_upd[3] ? cfg.data_id_high : cfg.data_id_low;
      data_id     = ids[{cap_cnt_upd[2:0], 3'b000} +: 8];
      crc_rx      = crc8_update(acc_upd, data_id) ^ CRC_XOROUT;
      crc_bad     = crc_rx != cap_crc_upd;
      delta       = cap_cnt_upd - last_counter_ff;
      if (crc_bad) begin
         status = ST_ERROR;
      end else if (delta > cfg.max_delta_counter) begin
         status = ST_WRONG_SEQ;
      end else if (delta == 4'd0) begin
         status = ST_REPEATED;
      end else if (delta != 4'd1) begin
         status = ST_OK_SOMELOST;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      count_in        = count_ff;
      acc_in          = acc_ff;
      cap_crc_in      = cap_crc_ff;
      cap_cnt_in      = cap_cnt_ff;
      last_counter_in = last_counter_ff;
      last_status_in  = last_status_ff;
      out_rsp.return_code      = RC_OK;
      out_rsp.check_status     = ST_NO_NEW_DATA;
      out_rsp.mapped_status    = SM_NO_NEW_DATA;
      out_rsp.received_counter = 4'd0;
      if (s1_none_ff) begin
         last_status_in = ST_NO_NEW_DATA;
      end else if (!s1_last_ff) begin
         count_in   = count_upd;
         acc_in     = acc_upd;
         cap_crc_in = cap_crc_upd;
         cap_cnt_in = cap_cnt_upd;
      end else if (len_bad) begin
         out_rsp.return_code   = RC_INPUT_WRONG;
         out_rsp.check_status  = last_status_ff;
         out_rsp.mapped_status = SM_ERROR;
      end else begin
         last_status_in = status;
         if (!crc_bad) begin
            last_counter_in = cap_cnt_upd;
         end
         out_rsp.check_status     = status;
         out_rsp.mapped_status    = map_status(status);
         out_rsp.received_counter = cap_cnt_upd;
      end
      // any result closes the message
      if (s1_none_ff || s1_last_ff) begin
         count_in   = '0;
         acc_in     = CRC_INIT;
         cap_crc_in = 8'd0;
         cap_cnt_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
         s1_none_ff <= req_no_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         count_ff        <= '0;
         acc_ff          <= CRC_INIT;
         cap_crc_ff      <= 8'd0;
         cap_cnt_ff      <= 4'd0;
         last_counter_ff <= LAST_COUNTER_RESET;
         last_status_ff  <= ST_ERROR;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_valid_ff && s1_adv) begin
            count_ff        <= count_in;
            acc_ff          <= acc_in;
            cap_crc_ff      <= cap_crc_in;
            cap_cnt_ff      <= cap_cnt_in;
            last_counter_ff <= last_counter_in;
            last_status_ff  <= last_status_in;
         end
      end
   end

endmodule
`default_nettype wire

### hdl/e2e22_out.sv
// Result word register toward the response channel.
`default_nettype none
module e2e22_out
   import e2e22_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    out_load,
   input  wire rsp_type out_rsp,
   output logic         out_free,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= out_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire
